// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the running average background
// unit. They check on the rising edge of clk_i and stay quiet while rst_ni is
// low. Synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every clock edge out of reset
`define MRAB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mrab: assertion failed");
// check that a condition implies a consequence in the same cycle
`define MRAB_ASSERT_IMPL(name, ante, cons) \
  `MRAB_ASSERT(name, (ante) |-> (cons))
`else
`define MRAB_ASSERT(name, prop)
`define MRAB_ASSERT_IMPL(name, ante, cons)
`endif
`endif

// File: hw/rtl/mrab_pkg.sv
// ----------------------------------------------------------------------------
// mrab_pkg
// Sizes, fixed point constants and shared types of the masked running average
// background unit.
// ----------------------------------------------------------------------------
package mrab_pkg;

  // frame and box limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_BOXES  = 8;

  // field widths fixed by the interface
  localparam int DIM_W  = 11;
  localparam int BOX_W  = 10;
  localparam int PIX_W  = 8;
  localparam int NUM_CH = 3;

  // derived sizes
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int CMP_W     = (COL_W > BOX_W) ? ((COL_W > ROW_W) ? COL_W : ROW_W)
                                             : ((BOX_W > ROW_W) ? BOX_W : ROW_W);
  localparam int BOX_CNT_W = $clog2(MAX_BOXES + 1);

  // Q8.16 estimate arithmetic
  localparam int EST_W      = 24;
  localparam int FRAC_W     = 16;
  localparam int TERM_W     = 18;
  localparam int DECAY_W    = 16;
  localparam int TERM_MUL_W = 26;
  localparam logic [DECAY_W-1:0]    DECAY_Q16 = DECAY_W'(64881);
  // round(p * 0.01 * 2^16) = (p * round(655.36 * 2^16) + 2^15) >> 16
  localparam logic [TERM_MUL_W-1:0] TERM_MUL  = TERM_MUL_W'(42949673);
  localparam logic [EST_W-1:0]      EST_MAX   = {EST_W{1'b1}};
  localparam logic [EST_W-1:0]      HALF_LSB8 = EST_W'(32768);

  // estimate memory
  localparam int EST_WORD_W = NUM_CH * EST_W;
  localparam int EST_DEPTH  = 2 ** ADDR_W;

  // queue depths
  localparam int QUEUE_DEPTH = 4;
  localparam int OFIFO_DEPTH = 2;

  // reset values of the frame size registers
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef enum logic {
    OP_BOX   = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } frame_cfg_t;

  typedef struct packed {
    logic [BOX_W-1:0] x0;
    logic [BOX_W-1:0] x1;
    logic [BOX_W-1:0] y0;
    logic [BOX_W-1:0] y1;
  } box_t;

  // one classified pixel on its way to the estimate update
  typedef struct packed {
    logic [ADDR_W-1:0]              addr;
    logic [NUM_CH-1:0][PIX_W-1:0]   pix;
    logic [NUM_CH-1:0][TERM_W-1:0]  term;
    logic                           add;
    logic                           first;
    logic                           last;
  } pix_desc_t;

  typedef logic [NUM_CH-1:0][EST_W-1:0] est_word_t;

  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0] bg;
    logic                         last;
  } result_t;

endpackage

// File: hw/rtl/mrab_ram.sv
// ----------------------------------------------------------------------------
// mrab_ram
// Simple dual port RAM: one write port, one read port with registered data.
// A read at the address written in the same cycle returns the old word.
// ----------------------------------------------------------------------------
module mrab_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read, read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mrab_queue.sv
// ----------------------------------------------------------------------------
// mrab_queue
// Short FIFO of classified pixels between the front and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrab_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mrab_pkg::pix_desc_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output mrab_pkg::pix_desc_t data_o,
  output logic                empty_o
);

  localparam int PtrW = (mrab_pkg::QUEUE_DEPTH > 1) ? $clog2(mrab_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(mrab_pkg::QUEUE_DEPTH + 1);

  mrab_pkg::pix_desc_t entry_q [mrab_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(mrab_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(mrab_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(mrab_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // store the word at the write pointer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  `MRAB_ASSERT_IMPL(q_no_overflow_a, push_i, !full_o)
  `MRAB_ASSERT(q_cnt_bound_a, cnt_q <= CntW'(mrab_pkg::QUEUE_DEPTH))

endmodule

// File: hw/rtl/mrab_front.sv
// ----------------------------------------------------------------------------
// mrab_front
// Front end: loads exclusion boxes, tracks the raster position and classifies
// each pixel (address, coverage, first frame, last pixel, blend term).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrab_front (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  mrab_pkg::frame_cfg_t                           cfg_i,
  input  logic                                           valid_i,
  input  logic                                           op_i,
  input  logic [mrab_pkg::BOX_W-1:0]                     box_left_i,
  input  logic [mrab_pkg::BOX_W-1:0]                     box_top_i,
  input  logic [mrab_pkg::BOX_W-1:0]                     box_right_i,
  input  logic [mrab_pkg::BOX_W-1:0]                     box_bottom_i,
  input  logic [mrab_pkg::NUM_CH-1:0][mrab_pkg::PIX_W-1:0] pix_i,
  output logic                                           q_push_o,
  output mrab_pkg::pix_desc_t                            q_data_o
);

  localparam int ColW   = mrab_pkg::COL_W;
  localparam int RowW   = mrab_pkg::ROW_W;
  localparam int CmpW   = mrab_pkg::CMP_W;
  localparam int BcW    = mrab_pkg::BOX_CNT_W;
  localparam int ProdW  = mrab_pkg::PIX_W + mrab_pkg::TERM_MUL_W + 1;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            first_q, first_d;
  logic [BcW-1:0]  box_cnt_q, box_cnt_d;
  mrab_pkg::box_t  boxes_q [mrab_pkg::MAX_BOXES];
  mrab_pkg::box_t  new_box;

  logic            pix_acc, box_acc;
  logic [ColW-1:0] col_lim;
  logic [RowW-1:0] row_lim;
  logic            last_col, last_row, last_pix;
  logic [mrab_pkg::MAX_BOXES-1:0] hit;
  logic [ProdW-1:0] term_prod [mrab_pkg::NUM_CH];

  assign pix_acc = valid_i && (mrab_pkg::op_e'(op_i) == mrab_pkg::OP_PIXEL);
  assign box_acc = valid_i && (mrab_pkg::op_e'(op_i) == mrab_pkg::OP_BOX);

  // last column and row index from the clamped frame size
  always_comb begin
    if (cfg_i.width == '0) begin
      col_lim = '0;
    end else if (32'(cfg_i.width) > 32'(mrab_pkg::MAX_WIDTH)) begin
      col_lim = ColW'(mrab_pkg::MAX_WIDTH - 1);
    end else begin
      col_lim = ColW'(cfg_i.width - mrab_pkg::DIM_W'(1));
    end
    if (cfg_i.height == '0) begin
      row_lim = '0;
    end else if (32'(cfg_i.height) > 32'(mrab_pkg::MAX_HEIGHT)) begin
      row_lim = RowW'(mrab_pkg::MAX_HEIGHT - 1);
    end else begin
      row_lim = RowW'(cfg_i.height - mrab_pkg::DIM_W'(1));
    end
  end

  assign last_col = (col_q >= col_lim);
  assign last_row = (row_q >= row_lim);
  assign last_pix = last_col && last_row;

  // test the position against every loaded box
  always_comb begin
    for (int i = 0; i < mrab_pkg::MAX_BOXES; i++) begin
      hit[i] = (BcW'(i) < box_cnt_q)
            && (CmpW'(col_q) >= CmpW'(boxes_q[i].x0))
            && (CmpW'(col_q) <= CmpW'(boxes_q[i].x1))
            && (CmpW'(row_q) >= CmpW'(boxes_q[i].y0))
            && (CmpW'(row_q) <= CmpW'(boxes_q[i].y1));
    end
  end

  // blend term per channel: pixel times 0.01 in Q16, rounded
  always_comb begin
    for (int c = 0; c < mrab_pkg::NUM_CH; c++) begin
      term_prod[c] = ProdW'(pix_i[c]) * ProdW'(mrab_pkg::TERM_MUL)
                   + ProdW'(mrab_pkg::HALF_LSB8);
    end
  end

  // build the queue word
  always_comb begin
    q_data_o.addr  = {row_q, col_q};
    q_data_o.pix   = pix_i;
    for (int c = 0; c < mrab_pkg::NUM_CH; c++) begin
      q_data_o.term[c] = term_prod[c][mrab_pkg::FRAC_W +: mrab_pkg::TERM_W];
    end
    q_data_o.add   = ~|hit;
    q_data_o.first = first_q;
    q_data_o.last  = last_pix;
  end

  assign q_push_o = pix_acc;

  // order the corners of an incoming box
  always_comb begin
    new_box.x0 = (box_left_i < box_right_i)  ? box_left_i  : box_right_i;
    new_box.x1 = (box_left_i < box_right_i)  ? box_right_i : box_left_i;
    new_box.y0 = (box_top_i  < box_bottom_i) ? box_top_i   : box_bottom_i;
    new_box.y1 = (box_top_i  < box_bottom_i) ? box_bottom_i : box_top_i;
  end

  // advance the raster position, drop boxes and first flag at frame end
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    first_d   = first_q;
    box_cnt_d = box_cnt_q;
    if (pix_acc) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d     = '0;
          first_d   = 1'b0;
          box_cnt_d = '0;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (box_acc && (box_cnt_q < BcW'(mrab_pkg::MAX_BOXES))) begin
      box_cnt_d = box_cnt_q + BcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      first_q   <= 1'b1;
      box_cnt_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      first_q   <= first_d;
      box_cnt_q <= box_cnt_d;
    end
  end

  // load a box into the next free slot
  for (genvar i = 0; i < mrab_pkg::MAX_BOXES; i++) begin : g_box
    always_ff @(posedge clk_i) begin
      if (box_acc && (box_cnt_q == BcW'(i))) begin
        boxes_q[i] <= new_box;
      end
    end
  end

  `MRAB_ASSERT(box_cnt_bound_a, box_cnt_q <= BcW'(mrab_pkg::MAX_BOXES))
  `MRAB_ASSERT(frame_wrap_a, (pix_acc && last_pix) |=> ({col_q, row_q, first_q, box_cnt_q} == '0))

endmodule

// File: hw/rtl/mrab_back.sv
// ----------------------------------------------------------------------------
// mrab_back
// Back end: reads the stored estimate, applies decay and blend, writes it
// back and queues the rounded 8 bit result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrab_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  mrab_pkg::pix_desc_t q_data_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output mrab_pkg::result_t   result_o
);

  localparam int EstW  = mrab_pkg::EST_W;
  localparam int MulW  = mrab_pkg::EST_W + mrab_pkg::DECAY_W + 1;
  localparam int OfPtrW = (mrab_pkg::OFIFO_DEPTH > 1) ? $clog2(mrab_pkg::OFIFO_DEPTH) : 1;
  localparam int OfCntW = $clog2(mrab_pkg::OFIFO_DEPTH + 1);

  logic                adv;
  logic                s1_valid_q;
  mrab_pkg::pix_desc_t s1_q;
  mrab_pkg::est_word_t rd_word, old_word, new_word;
  logic                fwd_valid_q;
  logic [mrab_pkg::ADDR_W-1:0] fwd_addr_q;
  mrab_pkg::est_word_t fwd_data_q;
  mrab_pkg::result_t   res;

  logic [MulW-1:0]   dec_prod [mrab_pkg::NUM_CH];
  logic [EstW:0]     blend    [mrab_pkg::NUM_CH];
  logic [EstW:0]     round8   [mrab_pkg::NUM_CH];

  mrab_pkg::result_t of_q [mrab_pkg::OFIFO_DEPTH];
  logic [OfPtrW-1:0] of_wr_q, of_rd_q;
  logic [OfCntW-1:0] of_cnt_q;
  logic              of_full, of_push, of_pop;

  // stall the pipe only when a result has nowhere to go
  assign of_full = (of_cnt_q == OfCntW'(mrab_pkg::OFIFO_DEPTH));
  assign adv     = !s1_valid_q || !of_full;
  assign q_pop_o = adv && !q_empty_i;
  assign of_push = adv && s1_valid_q;

  mrab_ram #(
    .Width(mrab_pkg::EST_WORD_W),
    .Depth(mrab_pkg::EST_DEPTH)
  ) u_est_ram (
    .clk_i  (clk_i),
    .we_i   (of_push),
    .waddr_i(s1_q.addr),
    .wdata_i(new_word),
    .re_i   (q_pop_o),
    .raddr_i(q_data_i.addr),
    .rdata_o(rd_word)
  );

  // hold the pixel whose estimate is being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_pop_o;
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= q_data_i;
      fwd_addr_q <= s1_q.addr;
      fwd_data_q <= new_word;
    end
  end

  // bypass the word written in the cycle this one was read
  assign old_word = (fwd_valid_q && (fwd_addr_q == s1_q.addr)) ? fwd_data_q : rd_word;

  // load on the first frame, else decay, blend and saturate; round per channel
  always_comb begin
    for (int c = 0; c < mrab_pkg::NUM_CH; c++) begin
      dec_prod[c] = MulW'(old_word[c]) * MulW'(mrab_pkg::DECAY_Q16)
                  + MulW'(mrab_pkg::HALF_LSB8);
      blend[c]    = (EstW+1)'(dec_prod[c][mrab_pkg::FRAC_W +: EstW])
                  + (s1_q.add ? (EstW+1)'(s1_q.term[c]) : '0);
      if (s1_q.first) begin
        new_word[c] = {s1_q.pix[c], {mrab_pkg::FRAC_W{1'b0}}};
      end else if (blend[c][EstW]) begin
        new_word[c] = mrab_pkg::EST_MAX;
      end else begin
        new_word[c] = blend[c][EstW-1:0];
      end
      round8[c] = (EstW+1)'(new_word[c]) + (EstW+1)'(mrab_pkg::HALF_LSB8);
      res.bg[c] = round8[c][EstW] ? '1 : round8[c][mrab_pkg::FRAC_W +: mrab_pkg::PIX_W];
    end
    res.last = s1_q.last;
  end

  // result FIFO
  assign empty_o  = (of_cnt_q == '0);
  assign of_pop   = pop_i && !empty_o;
  assign result_o = of_q[of_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q  <= '0;
      of_rd_q  <= '0;
      of_cnt_q <= '0;
    end else begin
      if (of_push) begin
        of_wr_q <= (of_wr_q == OfPtrW'(mrab_pkg::OFIFO_DEPTH - 1)) ? '0 : of_wr_q + OfPtrW'(1);
      end
      if (of_pop) begin
        of_rd_q <= (of_rd_q == OfPtrW'(mrab_pkg::OFIFO_DEPTH - 1)) ? '0 : of_rd_q + OfPtrW'(1);
      end
      if (of_push && !of_pop) begin
        of_cnt_q <= of_cnt_q + OfCntW'(1);
      end else if (of_pop && !of_push) begin
        of_cnt_q <= of_cnt_q - OfCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (of_push) begin
      of_q[of_wr_q] <= res;
    end
  end

  `MRAB_ASSERT_IMPL(of_no_overflow_a, of_push, of_cnt_q < OfCntW'(mrab_pkg::OFIFO_DEPTH))
  `MRAB_ASSERT(stall_holds_a, (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_q)))

endmodule

// File: hw/rtl/masked_running_average_background_unit.sv
// ----------------------------------------------------------------------------
// masked_running_average_background_unit
// Per-pixel RGB running average background over a raster stream, with up to
// MAX_BOXES exclusion boxes per frame that stop blending under them.
// ----------------------------------------------------------------------------
//
//   channel   handshake             word
//   -------   -------------------   -------------------------------------------
//   input     push / full           op, box corners, pixel red/green/blue
//   result    empty / pop           bg red/green/blue, frame_done
//   config    APB psel/penable      frame_width (0x0), frame_height (0x4)
//
// One item per clock while full is low; a box load gives no result, a pixel
// result goes through the pixel queue, read stage and result FIFO. The rate
// is set by the estimate RAM, one read and one write port, one pixel each per
// clock. The estimate store has no clearing pass, so items are taken right
// after reset. A result side stall fills the two entry result FIFO, the read
// stage and then the four entry pixel queue before full rises.
// ----------------------------------------------------------------------------
module masked_running_average_background_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue side
  input  logic                          push,
  output logic                          full,
  input  logic                          op_i,
  input  logic [mrab_pkg::BOX_W-1:0]    box_left_i,
  input  logic [mrab_pkg::BOX_W-1:0]    box_top_i,
  input  logic [mrab_pkg::BOX_W-1:0]    box_right_i,
  input  logic [mrab_pkg::BOX_W-1:0]    box_bottom_i,
  input  logic [mrab_pkg::PIX_W-1:0]    pixel_red_i,
  input  logic [mrab_pkg::PIX_W-1:0]    pixel_green_i,
  input  logic [mrab_pkg::PIX_W-1:0]    pixel_blue_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic [mrab_pkg::PIX_W-1:0]    bg_red_o,
  output logic [mrab_pkg::PIX_W-1:0]    bg_green_o,
  output logic [mrab_pkg::PIX_W-1:0]    bg_blue_o,
  output logic                          frame_done_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  mrab_pkg::frame_cfg_t cfg_q;
  mrab_pkg::reg_e       reg_idx;
  logic                 cfg_wr;

  logic                 in_valid;
  logic [mrab_pkg::NUM_CH-1:0][mrab_pkg::PIX_W-1:0] pix;
  logic                 q_push, q_full, q_pop, q_empty;
  mrab_pkg::pix_desc_t  q_wdata, q_rdata;
  mrab_pkg::result_t    result;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = mrab_pkg::reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= mrab_pkg::WIDTH_RESET;
      cfg_q.height <= mrab_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mrab_pkg::REG_FRAME_WIDTH:  cfg_q.width  <= pwdata[mrab_pkg::DIM_W-1:0];
        mrab_pkg::REG_FRAME_HEIGHT: cfg_q.height <= pwdata[mrab_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mrab_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_q.width);
      mrab_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_q.height);
      default:                    prdata = '0;
    endcase
  end

  // accept an item while the pixel queue has room
  assign full     = q_full;
  assign in_valid = push && !q_full;
  assign pix      = {pixel_blue_i, pixel_green_i, pixel_red_i};

  mrab_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (in_valid),
    .op_i        (op_i),
    .box_left_i  (box_left_i),
    .box_top_i   (box_top_i),
    .box_right_i (box_right_i),
    .box_bottom_i(box_bottom_i),
    .pix_i       (pix),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  mrab_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  mrab_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result)
  );

  // drive the result ports
  assign bg_red_o     = result.bg[0];
  assign bg_green_o   = result.bg[1];
  assign bg_blue_o    = result.bg[2];
  assign frame_done_o = result.last;

endmodule

// File: verif/masked_running_average_background_unit_test.sv
// ----------------------------------------------------------------------------
// masked_running_average_background_unit_test
// Self-checking bench for the masked running average background unit. A
// predictor in the bench keeps its own per-pixel Q8.16 estimates, box table
// and raster position, and works out the background word of every accepted
// pixel. Results are compared field by field in arrival order. The run loads
// the 16x16 corner of the estimate store in the first frame, then covers box
// loading, mid-frame resizing, an oversized height and a long random stretch
// with idle bursts on both sides, all inside that corner.
// ----------------------------------------------------------------------------
module masked_running_average_background_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 1100;
  localparam int QUIET_TAIL    = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int CORNER        = 16;

  // one word on the input side
  typedef struct {
    mrab_pkg::op_e                                    op;
    logic [mrab_pkg::BOX_W-1:0]                       left;
    logic [mrab_pkg::BOX_W-1:0]                       top;
    logic [mrab_pkg::BOX_W-1:0]                       right;
    logic [mrab_pkg::BOX_W-1:0]                       bottom;
    logic [mrab_pkg::NUM_CH-1:0][mrab_pkg::PIX_W-1:0] pix;
  } stream_word_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           push;
  logic                           full;
  logic                           op_i;
  logic [mrab_pkg::BOX_W-1:0]     box_left_i;
  logic [mrab_pkg::BOX_W-1:0]     box_top_i;
  logic [mrab_pkg::BOX_W-1:0]     box_right_i;
  logic [mrab_pkg::BOX_W-1:0]     box_bottom_i;
  logic [mrab_pkg::PIX_W-1:0]     pixel_red_i;
  logic [mrab_pkg::PIX_W-1:0]     pixel_green_i;
  logic [mrab_pkg::PIX_W-1:0]     pixel_blue_i;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [mrab_pkg::PIX_W-1:0]     bg_red_o;
  logic [mrab_pkg::PIX_W-1:0]     bg_green_o;
  logic [mrab_pkg::PIX_W-1:0]     bg_blue_o;
  logic                           frame_done_o;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [2:0]                     paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  // predictor state
  mrab_pkg::est_word_t            est_mem [int unsigned];
  bit                             first_frame;
  int unsigned                    col_cnt;
  int unsigned                    row_cnt;
  mrab_pkg::box_t                 box_list [mrab_pkg::MAX_BOXES];
  int unsigned                    box_cnt;
  logic [mrab_pkg::DIM_W-1:0]     cfg_width;
  logic [mrab_pkg::DIM_W-1:0]     cfg_height;
  mrab_pkg::result_t              bg_expect_q [$];

  // checking and throttling
  int unsigned                    mismatch_count;
  int unsigned                    stall_left;
  int unsigned                    quiet_cycles;
  bit                             idle_on;
  mrab_pkg::result_t              exp_res;
  logic [mrab_pkg::NUM_CH-1:0][mrab_pkg::PIX_W-1:0] got_bg;
  string                          chan_name [mrab_pkg::NUM_CH] = '{"red", "green", "blue"};

  masked_running_average_background_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .box_left_i    (box_left_i),
    .box_top_i     (box_top_i),
    .box_right_i   (box_right_i),
    .box_bottom_i  (box_bottom_i),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .empty         (empty),
    .pop           (pop),
    .bg_red_o      (bg_red_o),
    .bg_green_o    (bg_green_o),
    .bg_blue_o     (bg_blue_o),
    .frame_done_o  (frame_done_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic int unsigned clamp_dim(logic [mrab_pkg::DIM_W-1:0] v,
                                            int unsigned maxv);
    if (v == '0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // advance the predicted background by one word
  function automatic void update_background(stream_word_t w);
    int unsigned         wd;
    int unsigned         ht;
    int unsigned         x;
    int unsigned         y;
    int unsigned         addr;
    bit                  blend;
    bit                  last_col;
    bit                  last_row;
    logic [63:0]         acc;
    mrab_pkg::est_word_t est;
    mrab_pkg::result_t   res;
    // store a box with ordered corners, drop it when the table is full
    if (w.op == mrab_pkg::OP_BOX) begin
      if (box_cnt < mrab_pkg::MAX_BOXES) begin
        box_list[box_cnt].x0 = (w.left < w.right) ? w.left : w.right;
        box_list[box_cnt].x1 = (w.left < w.right) ? w.right : w.left;
        box_list[box_cnt].y0 = (w.top < w.bottom) ? w.top : w.bottom;
        box_list[box_cnt].y1 = (w.top < w.bottom) ? w.bottom : w.top;
        box_cnt++;
      end
      return;
    end
    wd   = clamp_dim(cfg_width, mrab_pkg::MAX_WIDTH);
    ht   = clamp_dim(cfg_height, mrab_pkg::MAX_HEIGHT);
    x    = (col_cnt < mrab_pkg::MAX_WIDTH) ? col_cnt : mrab_pkg::MAX_WIDTH - 1;
    y    = (row_cnt < mrab_pkg::MAX_HEIGHT) ? row_cnt : mrab_pkg::MAX_HEIGHT - 1;
    addr = y * mrab_pkg::MAX_WIDTH + x;
    // any loaded box over the pixel stops the blend
    blend = 1'b1;
    for (int i = 0; i < box_cnt; i++) begin
      if (x >= box_list[i].x0 && x <= box_list[i].x1 &&
          y >= box_list[i].y0 && y <= box_list[i].y1) blend = 1'b0;
    end
    est = est_mem.exists(addr) ? est_mem[addr] : '0;
    for (int c = 0; c < mrab_pkg::NUM_CH; c++) begin
      if (first_frame) begin
        acc = 64'(w.pix[c]) << mrab_pkg::FRAC_W;
      end else begin
        acc = (64'(est[c]) * 64'(mrab_pkg::DECAY_Q16) + 64'd32768) >> mrab_pkg::FRAC_W;
        if (blend) acc += (64'(w.pix[c]) * 64'd65536 + 64'd50) / 64'd100;
        if (acc > 64'(mrab_pkg::EST_MAX)) acc = 64'(mrab_pkg::EST_MAX);
      end
      est[c]    = acc[mrab_pkg::EST_W-1:0];
      acc       = (64'(est[c]) + 64'(mrab_pkg::HALF_LSB8)) >> mrab_pkg::FRAC_W;
      res.bg[c] = (acc > 64'd255) ? '1 : acc[mrab_pkg::PIX_W-1:0];
    end
    est_mem[addr] = est;
    last_col = (x >= wd - 1);
    last_row = (y >= ht - 1);
    res.last = last_col && last_row;
    bg_expect_q.push_back(res);
    // step the raster position, clear the boxes at the frame end
    if (last_col) begin
      col_cnt = 0;
      if (last_row) begin
        row_cnt     = 0;
        first_frame = 1'b0;
        box_cnt     = 0;
      end else begin
        row_cnt = y + 1;
      end
    end else begin
      col_cnt = x + 1;
    end
  endfunction

  function automatic stream_word_t make_box(int unsigned l, int unsigned t,
                                            int unsigned r, int unsigned b);
    stream_word_t w;
    w.op     = mrab_pkg::OP_BOX;
    w.left   = mrab_pkg::BOX_W'(l);
    w.top    = mrab_pkg::BOX_W'(t);
    w.right  = mrab_pkg::BOX_W'(r);
    w.bottom = mrab_pkg::BOX_W'(b);
    w.pix    = '0;
    return w;
  endfunction

  function automatic stream_word_t make_pixel(logic [mrab_pkg::PIX_W-1:0] r,
                                              logic [mrab_pkg::PIX_W-1:0] g,
                                              logic [mrab_pkg::PIX_W-1:0] b);
    stream_word_t w;
    w        = make_box(0, 0, 0, 0);
    w.op     = mrab_pkg::OP_PIXEL;
    w.pix[0] = r;
    w.pix[1] = g;
    w.pix[2] = b;
    return w;
  endfunction

  // near boxes have corners from 0 to 17, around the small frames, far ones anywhere
  function automatic stream_word_t random_box(bit near);
    stream_word_t w;
    w.op     = mrab_pkg::OP_BOX;
    w.left   = near ? mrab_pkg::BOX_W'($urandom_range(0, 17)) : mrab_pkg::BOX_W'($urandom);
    w.top    = near ? mrab_pkg::BOX_W'($urandom_range(0, 17)) : mrab_pkg::BOX_W'($urandom);
    w.right  = near ? mrab_pkg::BOX_W'($urandom_range(0, 17)) : mrab_pkg::BOX_W'($urandom);
    w.bottom = near ? mrab_pkg::BOX_W'($urandom_range(0, 17)) : mrab_pkg::BOX_W'($urandom);
    w.pix    = (mrab_pkg::NUM_CH*mrab_pkg::PIX_W)'($urandom);
    return w;
  endfunction

  // random pixel, unused box fields toggle too
  function automatic stream_word_t random_pixel();
    stream_word_t w;
    w    = random_box(1'b0);
    w.op = mrab_pkg::OP_PIXEL;
    for (int c = 0; c < mrab_pkg::NUM_CH; c++) begin
      case ($urandom_range(0, 9))
        0:       w.pix[c] = '0;
        1:       w.pix[c] = '1;
        default: w.pix[c] = mrab_pkg::PIX_W'($urandom);
      endcase
    end
    return w;
  endfunction

  // hand one word to the block, with an optional idle burst before it
  task automatic send_word(stream_word_t w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    push          <= 1'b1;
    op_i          <= w.op;
    box_left_i    <= w.left;
    box_top_i     <= w.top;
    box_right_i   <= w.right;
    box_bottom_i  <= w.bottom;
    pixel_red_i   <= w.pix[0];
    pixel_green_i <= w.pix[1];
    pixel_blue_i  <= w.pix[2];
    do @(posedge clk_i); while (full);
    update_background(w);
  endtask

  // hold the input until every expected word is out, then let the pipe empty
  task automatic settle_block();
    push <= 1'b0;
    while (bg_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup and access phases, then idle on the bus
  task automatic write_frame_reg(mrab_pkg::reg_e idx, logic [mrab_pkg::DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {21'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == mrab_pkg::REG_FRAME_WIDTH) cfg_width = value;
    else cfg_height = value;
  endtask

  // send pixels until the raster position is back at a frame start
  task automatic finish_frame();
    do send_word(random_pixel()); while (col_cnt != 0 || row_cnt != 0);
  endtask

  // first frame: load the corner that every later frame stays inside
  task automatic test_first_frame();
    write_frame_reg(mrab_pkg::REG_FRAME_WIDTH, mrab_pkg::DIM_W'(CORNER));
    write_frame_reg(mrab_pkg::REG_FRAME_HEIGHT, mrab_pkg::DIM_W'(CORNER));
    // boxes have no effect while the store is loaded
    send_word(make_box(0, 0, 1023, 1023));
    send_word(random_box(1'b1));
    finish_frame();
  endtask

  // swapped corners, a full table and dropped boxes, extreme pixels
  task automatic test_box_table();
    settle_block();
    write_frame_reg(mrab_pkg::REG_FRAME_WIDTH, mrab_pkg::DIM_W'(4));
    write_frame_reg(mrab_pkg::REG_FRAME_HEIGHT, mrab_pkg::DIM_W'(2));
    send_word(make_box(2, 1, 1, 1));
    send_word(make_box(3, 1, 3, 0));
    repeat (mrab_pkg::MAX_BOXES - 2) send_word(make_box(1023, 1023, 1000, 1000));
    send_word(make_box(0, 0, 1023, 1023));
    send_word(make_box(0, 0, 1023, 1023));
    // masked frame, then a frame with the table cleared
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) send_word(make_pixel('0, '1, '0));
      else send_word(make_pixel('1, '0, '1));
    end
  endtask

  // shrink the width past the current column, then the height past the row;
  // then run an oversized height and end the frame by shrinking it
  task automatic test_mid_frame_resize();
    settle_block();
    write_frame_reg(mrab_pkg::REG_FRAME_WIDTH, mrab_pkg::DIM_W'(8));
    write_frame_reg(mrab_pkg::REG_FRAME_HEIGHT, mrab_pkg::DIM_W'(8));
    repeat (5) send_word(random_pixel());
    settle_block();
    write_frame_reg(mrab_pkg::REG_FRAME_WIDTH, mrab_pkg::DIM_W'(3));
    repeat (4) send_word(random_pixel());
    settle_block();
    write_frame_reg(mrab_pkg::REG_FRAME_HEIGHT, mrab_pkg::DIM_W'(1));
    finish_frame();
    settle_block();
    write_frame_reg(mrab_pkg::REG_FRAME_WIDTH, mrab_pkg::DIM_W'(4));
    write_frame_reg(mrab_pkg::REG_FRAME_HEIGHT, mrab_pkg::DIM_W'(2047));
    repeat (12) send_word(random_pixel());
    settle_block();
    write_frame_reg(mrab_pkg::REG_FRAME_HEIGHT, mrab_pkg::DIM_W'(2));
    finish_frame();
  endtask

  // random geometry inside the loaded corner, boxes mostly at frame start
  task automatic test_random_traffic();
    int unsigned pixels_sent;
    int unsigned phase;
    pixels_sent = 0;
    phase       = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      settle_block();
      idle_on = (pixels_sent + QUIET_TAIL < RANDOM_PIXELS) && ($urandom_range(0, 3) != 0);
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_frame_reg(mrab_pkg::REG_FRAME_WIDTH,
                        mrab_pkg::DIM_W'($urandom_range(0, CORNER)));
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_frame_reg(mrab_pkg::REG_FRAME_HEIGHT,
                        mrab_pkg::DIM_W'($urandom_range(0, CORNER)));
      phase++;
      repeat ($urandom_range(20, 90)) begin
        if (col_cnt == 0 && row_cnt == 0 && box_cnt == 0 && $urandom_range(0, 1) == 0)
          repeat ($urandom_range(1, 10)) send_word(random_box($urandom_range(0, 3) != 0));
        if ($urandom_range(0, 11) == 0) begin
          send_word(random_box($urandom_range(0, 1) == 1));
        end else begin
          send_word(random_pixel());
          pixels_sent++;
        end
      end
    end
  endtask

  // compare each popped word with the oldest prediction, then throttle pop
  always @(posedge clk_i) begin
    got_bg = {bg_blue_o, bg_green_o, bg_red_o};
    if (pop && !empty) begin
      if (bg_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual bg %h %h %h done %b",
                 $time, bg_red_o, bg_green_o, bg_blue_o, frame_done_o);
      end else begin
        exp_res = bg_expect_q.pop_front();
        for (int c = 0; c < mrab_pkg::NUM_CH; c++) begin
          if (got_bg[c] !== exp_res.bg[c]) begin
            mismatch_count++;
            $display("%0t: bg_%s expected %h actual %h", $time, chan_name[c],
                     exp_res.bg[c], got_bg[c]);
          end
        end
        if (frame_done_o !== exp_res.last) begin
          mismatch_count++;
          $display("%0t: frame_done expected %b actual %b", $time, exp_res.last,
                   frame_done_o);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_on && rst_ni && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni;
    end
  end

  // end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    op_i          <= mrab_pkg::OP_PIXEL;
    box_left_i    <= '0;
    box_top_i     <= '0;
    box_right_i   <= '0;
    box_bottom_i  <= '0;
    pixel_red_i   <= '0;
    pixel_green_i <= '0;
    pixel_blue_i  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    idle_on        = 1'b1;
    first_frame    = 1'b1;
    col_cnt        = 0;
    row_cnt        = 0;
    box_cnt        = 0;
    cfg_width      = mrab_pkg::WIDTH_RESET;
    cfg_height     = mrab_pkg::HEIGHT_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_frame();
    test_box_table();
    test_mid_frame_resize();
    test_random_traffic();
    settle_block();
    if (mismatch_count == 0 && bg_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
